// ----- rtl/core/rpcc_pkg.sv -----
// ----------------------------------------------------------------------------
// rpcc_pkg
// shared types, widths and constant curve tables for the color correction unit
// ----------------------------------------------------------------------------
package rpcc_pkg;

  // fixed-point setup
  localparam int LINEAR_BITS      = 16;
  localparam int CURVE_INDEX_BITS = 12;
  localparam int COEF_W           = 16;
  localparam int COEF_FRAC        = 14;
  localparam int ROW_W            = 3 * COEF_W;
  localparam int CHAN_W           = 8;
  localparam int CODE_W           = 8;
  localparam int SRC_BITS         = 5;
  localparam int NUM_CODES        = 1 << CODE_W;
  localparam int NUM_SRC          = 1 << SRC_BITS;

  // derived widths
  localparam int FB       = LINEAR_BITS + COEF_FRAC;
  localparam int LIN_W    = LINEAR_BITS + 1;
  localparam int PROD_W   = COEF_W + LIN_W + 1;
  localparam int ACC_W    = PROD_W + 2;
  localparam int V_W      = FB + 1;
  localparam int IDXM_W   = V_W + CURVE_INDEX_BITS + 1;
  localparam int ENC_STAGES = CODE_W;

  localparam logic [CURVE_INDEX_BITS-1:0] CURVE_MAX = '1;
  localparam logic [V_W-1:0] V_ONE  = {1'b1, {FB{1'b0}}};
  localparam logic [IDXM_W-1:0] V_HALF = IDXM_W'(1) << (FB - 1);

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_ENABLE = 2'd0,
    REG_RED    = 2'd1,
    REG_GREEN  = 2'd2,
    REG_BLUE   = 2'd3
  } reg_idx_t;

  // per-item sideband that travels with the pipeline
  typedef struct packed {
    logic              valid;
    logic              en;
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              last;
  } side_t;

  typedef logic [2:0][CURVE_INDEX_BITS-1:0] idx3_t;
  typedef logic [2:0][CODE_W-1:0]           code3_t;
  typedef logic [2:0][ROW_W-1:0]            rows_t;
  typedef logic [NUM_SRC-1:0][LIN_W-1:0]    lin_tab_t;
  typedef logic [NUM_CODES-1:0][CURVE_INDEX_BITS-1:0] thr_tab_t;

  // gamma 2.2 expansion of a 5-bit code, Q24
  localparam logic [24:0] GAMMA_Q24 [NUM_SRC] = '{
    25'd0, 25'd8785, 25'd40364, 25'd98490, 25'd185463, 25'd303011, 25'd452540,
    25'd635243, 25'd852163, 25'd1104226, 25'd1392273, 25'd1717072, 25'd2079329,
    25'd2479704, 25'd2918812, 25'd3397233, 25'd3915511, 25'd4474166, 25'd5073691,
    25'd5714555, 25'd6397208, 25'd7122081, 25'd7889586, 25'd8700130, 25'd9554088,
    25'd10451834, 25'd11393728, 25'd12380118, 25'd13411338, 25'd14487722,
    25'd15609582, 25'd16777216
  };

  // linear table rounded half up to LINEAR_BITS fraction bits
  function automatic lin_tab_t make_lin();
    lin_tab_t    t;
    logic [63:0] g;
    t = '0;
    for (int c = 0; c < NUM_SRC; c++) begin
      g = 64'(GAMMA_Q24[c]);
      if (LINEAR_BITS >= 24) begin
        t[c] = LIN_W'(g << (LINEAR_BITS - 24));
      end else begin
        t[c] = LIN_W'((g + ((64'd1 << (24 - LINEAR_BITS)) >> 1)) >> (24 - LINEAR_BITS));
      end
    end
    return t;
  endfunction

  localparam lin_tab_t LIN_TAB = make_lin();

  // Q0.30 product with half-up rounding
  function automatic logic [63:0] mul_q30(logic [63:0] a, logic [63:0] b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic logic [63:0] pow5_q30(logic [63:0] w);
    logic [63:0] w2;
    logic [63:0] w4;
    w2 = mul_q30(w, w);
    w4 = mul_q30(w2, w2);
    return mul_q30(w4, w);
  endfunction

  // largest w with w^5 <= s, bisection
  function automatic logic [63:0] root5_q30(logic [63:0] s);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    lo = 64'd0;
    hi = 64'd1 << 30;
    while (lo < hi) begin
      mid = (lo + hi + 64'd1) >> 1;
      if (pow5_q30(mid) <= s) lo = mid;
      else hi = mid - 64'd1;
    end
    return lo;
  endfunction

  // curve index at which each sRGB code starts; built at elaboration
  function automatic thr_tab_t make_thr();
    thr_tab_t    t;
    logic [63:0] e;
    logic [63:0] u;
    logic [63:0] s;
    logic [63:0] num;
    logic [63:0] half;
    t = '0;
    half = 64'(CURVE_MAX) >> 1;
    for (int k = 1; k < NUM_CODES; k++) begin
      if (k <= 10) begin
        e = ((64'(200 * k - 100) << 30) + 64'd329460) / 64'd658920;
      end else begin
        u = ((64'(200 * k + 2705) << 30) + 64'd26902) / 64'd53805;
        s = mul_q30(u, u);
        e = mul_q30(s, root5_q30(s));
      end
      num = e * 64'(CURVE_MAX);
      if (num <= half) t[k] = '0;
      else t[k] = CURVE_INDEX_BITS'((num - half + (64'd1 << 30) - 64'd1) >> 30);
    end
    return t;
  endfunction

  localparam thr_tab_t THR_TAB = make_thr();

endpackage

// ----- rtl/core/rpcc_pix_in_if.sv -----
// ----------------------------------------------------------------------------
// rpcc_pix_in_if
// input pixel channel: valid/ready handshake with an ARGB payload
// ----------------------------------------------------------------------------
interface rpcc_pix_in_if;
  logic                       valid;
  logic                       ready;
  logic [rpcc_pkg::CHAN_W-1:0] alpha_in;
  logic [rpcc_pkg::CHAN_W-1:0] red_in;
  logic [rpcc_pkg::CHAN_W-1:0] green_in;
  logic [rpcc_pkg::CHAN_W-1:0] blue_in;
  logic                       last_in;

  modport source (output valid, alpha_in, red_in, green_in, blue_in, last_in,
                  input ready);
  modport sink   (input valid, alpha_in, red_in, green_in, blue_in, last_in,
                  output ready);
endinterface

// ----- rtl/core/rpcc_pix_out_if.sv -----
// ----------------------------------------------------------------------------
// rpcc_pix_out_if
// result pixel channel: valid/ready handshake with an ARGB payload
// ----------------------------------------------------------------------------
interface rpcc_pix_out_if;
  logic                       valid;
  logic                       ready;
  logic [rpcc_pkg::CHAN_W-1:0] alpha_out;
  logic [rpcc_pkg::CHAN_W-1:0] red_out;
  logic [rpcc_pkg::CHAN_W-1:0] green_out;
  logic [rpcc_pkg::CHAN_W-1:0] blue_out;
  logic                       last_out;

  modport source (output valid, alpha_out, red_out, green_out, blue_out, last_out,
                  input ready);
  modport sink   (input valid, alpha_out, red_out, green_out, blue_out, last_out,
                  output ready);
endinterface

// ----- rtl/core/rpcc_cfg_if.sv -----
// ----------------------------------------------------------------------------
// rpcc_cfg_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
interface rpcc_cfg_if;
  logic                        valid;
  logic                        ready;
  rpcc_pkg::reg_idx_t          index;
  logic [rpcc_pkg::ROW_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/rpcc_matrix.sv -----
// ----------------------------------------------------------------------------
// rpcc_matrix
// gamma expansion, 3x3 matrix, clamp and curve index, four register stages
// ----------------------------------------------------------------------------
module rpcc_matrix (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  rpcc_pkg::side_t       side_i,
  input  rpcc_pkg::rows_t       rows,
  output rpcc_pkg::side_t       side_o,
  output rpcc_pkg::idx3_t       idx_o
);

  // stage registers
  rpcc_pkg::side_t s1_r, s1_nxt, s2_r, s3_r, s4_r;
  logic [2:0][rpcc_pkg::LIN_W-1:0]         lin_r, lin_nxt;
  logic signed [rpcc_pkg::PROD_W-1:0]      prod_r [3][3];
  logic signed [rpcc_pkg::PROD_W-1:0]      prod_nxt [3][3];
  logic [2:0][rpcc_pkg::V_W-1:0]           v_r, v_nxt;
  rpcc_pkg::idx3_t                         idx_r, idx_nxt;

  // stage 1: top five bits through the linear table
  always_comb begin
    s1_nxt = side_i;
    lin_nxt[0] = rpcc_pkg::LIN_TAB[side_i.red[7:3]];
    lin_nxt[1] = rpcc_pkg::LIN_TAB[side_i.green[7:3]];
    lin_nxt[2] = rpcc_pkg::LIN_TAB[side_i.blue[7:3]];
  end

  // stage 2: nine coefficient products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_nxt[i][j] = $signed(rows[i][rpcc_pkg::COEF_W*j +: rpcc_pkg::COEF_W])
                         * $signed({1'b0, lin_r[j]});
      end
    end
  end

  // stage 3: row sums clamped to [0, 1.0]
  always_comb begin
    logic signed [rpcc_pkg::ACC_W-1:0] acc;
    for (int i = 0; i < 3; i++) begin
      acc = rpcc_pkg::ACC_W'(prod_r[i][0]) + rpcc_pkg::ACC_W'(prod_r[i][1])
          + rpcc_pkg::ACC_W'(prod_r[i][2]);
      if (acc[rpcc_pkg::ACC_W-1]) begin
        v_nxt[i] = '0;
      end else if (acc[rpcc_pkg::ACC_W-2:0] > (rpcc_pkg::ACC_W-1)'(rpcc_pkg::V_ONE)) begin
        v_nxt[i] = rpcc_pkg::V_ONE;
      end else begin
        v_nxt[i] = acc[rpcc_pkg::V_W-1:0];
      end
    end
  end

  // stage 4: scale to curve index, v * (2^n - 1) as shift and subtract
  always_comb begin
    logic [rpcc_pkg::IDXM_W-1:0] scaled;
    for (int i = 0; i < 3; i++) begin
      scaled = (rpcc_pkg::IDXM_W'(v_r[i]) << rpcc_pkg::CURVE_INDEX_BITS)
             - rpcc_pkg::IDXM_W'(v_r[i]) + rpcc_pkg::V_HALF;
      idx_nxt[i] = scaled[rpcc_pkg::FB +: rpcc_pkg::CURVE_INDEX_BITS];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      lin_r  <= lin_nxt;
      prod_r <= prod_nxt;
      v_r    <= v_nxt;
      idx_r  <= idx_nxt;
    end
  end

  // sideband, valid cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
      s2_r.valid <= 1'b0;
      s3_r.valid <= 1'b0;
      s4_r.valid <= 1'b0;
    end else if (adv) begin
      s1_r <= s1_nxt;
      s2_r <= s1_r;
      s3_r <= s2_r;
      s4_r <= s3_r;
    end
  end

  assign side_o = s4_r;
  assign idx_o  = idx_r;

endmodule

// ----- rtl/core/rpcc_encode.sv -----
// ----------------------------------------------------------------------------
// rpcc_encode
// sRGB encoding by binary search over code thresholds, one code bit per stage
// ----------------------------------------------------------------------------
module rpcc_encode (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  rpcc_pkg::side_t  side_i,
  input  rpcc_pkg::idx3_t  idx_i,
  output rpcc_pkg::side_t  side_o,
  output rpcc_pkg::code3_t code_o
);

  rpcc_pkg::side_t  side_r [rpcc_pkg::ENC_STAGES];
  rpcc_pkg::idx3_t  idx_r  [rpcc_pkg::ENC_STAGES];
  rpcc_pkg::code3_t code_r [rpcc_pkg::ENC_STAGES];

  for (genvar s = 0; s < rpcc_pkg::ENC_STAGES; s++) begin : g_stage
    localparam int BIT = rpcc_pkg::ENC_STAGES - 1 - s;

    rpcc_pkg::side_t  side_prev;
    rpcc_pkg::idx3_t  idx_prev;
    rpcc_pkg::code3_t code_prev;
    rpcc_pkg::code3_t code_nxt;

    // stage input
    if (s == 0) begin : g_first
      assign side_prev = side_i;
      assign idx_prev  = idx_i;
      assign code_prev = '0;
    end else begin : g_next
      assign side_prev = side_r[s-1];
      assign idx_prev  = idx_r[s-1];
      assign code_prev = code_r[s-1];
    end

    // try setting this bit: keep it when its threshold is reached
    always_comb begin
      logic [rpcc_pkg::CODE_W-1:0] cand;
      for (int i = 0; i < 3; i++) begin
        cand = code_prev[i] | (rpcc_pkg::CODE_W'(1) << BIT);
        if (rpcc_pkg::THR_TAB[cand] <= idx_prev[i]) code_nxt[i] = cand;
        else code_nxt[i] = code_prev[i];
      end
    end

    // payload registers
    always_ff @(posedge clk) begin
      if (adv) begin
        idx_r[s]  <= idx_prev;
        code_r[s] <= code_nxt;
      end
    end

    // sideband, valid cleared by reset
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[s].valid <= 1'b0;
      end else if (adv) begin
        side_r[s] <= side_prev;
      end
    end
  end

  assign side_o = side_r[rpcc_pkg::ENC_STAGES-1];
  assign code_o = code_r[rpcc_pkg::ENC_STAGES-1];

endmodule

// ----- rtl/core/retro_pixel_color_correction_unit.sv -----
// ----------------------------------------------------------------------------
// retro_pixel_color_correction_unit
// pipeline: input transaction to result valid passes 4 matrix stages,
//   8 encode stages and 1 output register
// throughput: one pixel per cycle; the whole pipeline holds while the output
//   register is full and not taken
// reset: synchronous active-low rst_n clears stage valid bits, disables
//   correction and loads the identity matrix
// ----------------------------------------------------------------------------
module retro_pixel_color_correction_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  rpcc_pix_in_if.sink           in_pix,
  rpcc_pix_out_if.source        out_pix,
  rpcc_cfg_if.sink              cfg_wr
);

  logic             enable_r;
  rpcc_pkg::rows_t  rows_r;
  logic             adv;
  rpcc_pkg::side_t  side_in;
  rpcc_pkg::side_t  side_mtx;
  rpcc_pkg::idx3_t  idx_mtx;
  rpcc_pkg::side_t  side_enc;
  rpcc_pkg::code3_t code_enc;
  rpcc_pkg::side_t  out_r;
  rpcc_pkg::side_t  out_nxt;

  // configuration registers, always ready
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= 1'b0;
      rows_r[0] <= rpcc_pkg::ROW_W'(1 << rpcc_pkg::COEF_FRAC);
      rows_r[1] <= rpcc_pkg::ROW_W'(1 << rpcc_pkg::COEF_FRAC) << rpcc_pkg::COEF_W;
      rows_r[2] <= rpcc_pkg::ROW_W'(1 << rpcc_pkg::COEF_FRAC) << (2 * rpcc_pkg::COEF_W);
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        rpcc_pkg::REG_ENABLE: enable_r  <= cfg_wr.data[0];
        rpcc_pkg::REG_RED:    rows_r[0] <= cfg_wr.data;
        rpcc_pkg::REG_GREEN:  rows_r[1] <= cfg_wr.data;
        rpcc_pkg::REG_BLUE:   rows_r[2] <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // pipeline advances whenever the output register can take a result
  assign adv          = !out_r.valid || out_pix.ready;
  assign in_pix.ready = adv;

  // input transaction into sideband
  always_comb begin
    side_in.valid = in_pix.valid;
    side_in.en    = enable_r;
    side_in.alpha = in_pix.alpha_in;
    side_in.red   = in_pix.red_in;
    side_in.green = in_pix.green_in;
    side_in.blue  = in_pix.blue_in;
    side_in.last  = in_pix.last_in;
  end

  rpcc_matrix u_matrix (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .side_i (side_in),
    .rows   (rows_r),
    .side_o (side_mtx),
    .idx_o  (idx_mtx)
  );

  rpcc_encode u_encode (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .side_i (side_mtx),
    .idx_i  (idx_mtx),
    .side_o (side_enc),
    .code_o (code_enc)
  );

  // corrected codes or the original pixel
  always_comb begin
    out_nxt = side_enc;
    if (side_enc.en) begin
      out_nxt.red   = code_enc[0];
      out_nxt.green = code_enc[1];
      out_nxt.blue  = code_enc[2];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_pix.valid     = out_r.valid;
  assign out_pix.alpha_out = out_r.alpha;
  assign out_pix.red_out   = out_r.red;
  assign out_pix.green_out = out_r.green;
  assign out_pix.blue_out  = out_r.blue;
  assign out_pix.last_out  = out_r.last;

endmodule

// ----- test/tb_retro_pixel_color_correction_unit.sv -----
// ----------------------------------------------------------------------------
// tb_retro_pixel_color_correction_unit
// Self-checking bench for the color correction unit. Pixels go in over a
// valid/ready stream with random gaps and output back-pressure. Each accepted
// transaction is run through an in-bench gamma / matrix / sRGB predictor. Each
// result is compared field by field against the oldest expected pixel. The
// matrix and enable registers are changed between phases, only when the
// pipeline has drained.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

  localparam int LATENCY      = 13;
  localparam int DRAIN_CYCLES = LATENCY + 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASES       = 7;
  localparam int PHASE_ITEMS  = 100;

  localparam longint unsigned ONE_Q30     = 64'd1 << 30;
  localparam longint unsigned CURVE_STEPS =
    (64'd1 << rpcc_pkg::CURVE_INDEX_BITS) - 64'd1;
  localparam int              MIX_FB      = rpcc_pkg::LINEAR_BITS + 14;

  // gamma 2.2 expansion of each 5-bit source code, Q24
  localparam longint unsigned GAMMA_TABLE [32] = '{
    0, 8785, 40364, 98490, 185463, 303011, 452540, 635243,
    852163, 1104226, 1392273, 1717072, 2079329, 2479704, 2918812, 3397233,
    3915511, 4474166, 5073691, 5714555, 6397208, 7122081, 7889586, 8700130,
    9554088, 10451834, 11393728, 12380118, 13411338, 14487722, 15609582, 16777216
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rpcc_pix_in_if  pix_in ();
  rpcc_pix_out_if pix_out ();
  rpcc_cfg_if     cfg ();

  retro_pixel_color_correction_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix_in),
    .out_pix (pix_out),
    .cfg_wr  (cfg)
  );

  // bench copy of the registers
  logic        cur_enable;
  logic [47:0] cur_rows [3];

  longint unsigned srgb_edge [256];
  pixel_t          expected_q [$];
  int              errors;
  int              pixels_sent;
  int              pixels_checked;
  int              cfg_writes;
  int              cycle_count;
  bit              calm;

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint unsigned q30_product(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  // largest w with w^5 <= s in Q0.30
  function automatic longint unsigned fifth_root_q30(longint unsigned s);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned w2;
    longint unsigned w4;
    lo = 0;
    hi = ONE_Q30;
    while (lo < hi) begin
      mid = (lo + hi + 64'd1) >> 1;
      w2 = q30_product(mid, mid);
      w4 = q30_product(w2, w2);
      if (q30_product(w4, mid) <= s) lo = mid;
      else hi = mid - 64'd1;
    end
    return lo;
  endfunction

  // linear-light thresholds at which each 8-bit sRGB code begins
  task automatic build_srgb_edges();
    longint unsigned u;
    longint unsigned s;
    srgb_edge[0] = 0;
    for (int k = 1; k <= 10; k++) begin
      srgb_edge[k] = ((longint'(200 * k - 100) << 30) + 64'd329460) / 64'd658920;
    end
    for (int k = 11; k <= 255; k++) begin
      u = ((longint'(200 * k + 2705) << 30) + 64'd26902) / 64'd53805;
      s = q30_product(u, u);
      srgb_edge[k] = q30_product(s, fifth_root_q30(s));
    end
  endtask

  function automatic longint lin_light(logic [7:0] chan);
    int sh;
    sh = 24 - rpcc_pkg::LINEAR_BITS;
    return longint'((GAMMA_TABLE[chan[7:3]] + ((64'd1 << sh) >> 1)) >> sh);
  endfunction

  // one matrix row, clamp, curve index and sRGB code
  function automatic logic [7:0] encode_row(logic [47:0] row, longint lr, longint lg,
                                            longint lb);
    longint          acc;
    longint unsigned v;
    longint unsigned idx;
    longint unsigned x;
    int              code;
    acc = longint'($signed(row[15:0])) * lr + longint'($signed(row[31:16])) * lg
        + longint'($signed(row[47:32])) * lb;
    if (acc < 0) acc = 0;
    if (acc > (longint'(1) << MIX_FB)) acc = longint'(1) << MIX_FB;
    v = acc;
    idx = (v * CURVE_STEPS + (64'd1 << (MIX_FB - 1))) >> MIX_FB;
    x = (idx * ONE_Q30 + (CURVE_STEPS >> 1)) / CURVE_STEPS;
    code = 0;
    while (code < 255 && srgb_edge[code + 1] <= x) code++;
    return 8'(code);
  endfunction

  function automatic pixel_t correct_pixel(pixel_t p);
    pixel_t q;
    longint lr;
    longint lg;
    longint lb;
    q = p;
    if (cur_enable) begin
      lr = lin_light(p.red);
      lg = lin_light(p.green);
      lb = lin_light(p.blue);
      q.red   = encode_row(cur_rows[0], lr, lg, lb);
      q.green = encode_row(cur_rows[1], lr, lg, lb);
      q.blue  = encode_row(cur_rows[2], lr, lg, lb);
    end
    return q;
  endfunction

  // ---------------------------------------------------------------- drivers

  // one pixel transaction; entered and left at a falling edge
  task automatic send_pixel(input logic [7:0] a, input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic l);
    pixel_t p;
    p = '{alpha: a, red: r, green: g, blue: b, last: l};
    if (!calm) begin
      while ($urandom_range(0, 99) < 19) begin
        pix_in.valid <= 1'b0;
        @(negedge clk);
      end
    end
    pix_in.valid    <= 1'b1;
    pix_in.alpha_in <= a;
    pix_in.red_in   <= r;
    pix_in.green_in <= g;
    pix_in.blue_in  <= b;
    pix_in.last_in  <= l;
    do @(posedge clk); while (!pix_in.ready);
    expected_q.push_back(correct_pixel(p));
    pixels_sent++;
    @(negedge clk);
  endtask

  // register write; only called with the pipeline drained
  task automatic cfg_write(input rpcc_pkg::reg_idx_t idx, input logic [47:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      rpcc_pkg::REG_ENABLE: cur_enable = data[0];
      rpcc_pkg::REG_RED:    cur_rows[0] = data;
      rpcc_pkg::REG_GREEN:  cur_rows[1] = data;
      rpcc_pkg::REG_BLUE:   cur_rows[2] = data;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg.valid <= 1'b0;
    @(negedge clk);
  endtask

  // stop sending, wait for every expected pixel, then let the pipe empty
  task automatic wait_idle();
    pix_in.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // random output back-pressure
  always @(negedge clk) begin
    pix_out.ready <= calm || ($urandom_range(0, 99) >= 19);
  end

  // ---------------------------------------------------------------- checker

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    pixel_t got;
    pixel_t want;
    if (rst_n && pix_out.valid && pix_out.ready) begin
      got = '{alpha: pix_out.alpha_out, red: pix_out.red_out, green: pix_out.green_out,
              blue: pix_out.blue_out, last: pix_out.last_out};
      if (expected_q.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        check_field("alpha", want.alpha, got.alpha);
        check_field("red", want.red, got.red);
        check_field("green", want.green, got.green);
        check_field("blue", want.blue, got.blue);
        check_field("last", 8'(want.last), 8'(got.last));
        pixels_checked++;
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic [7:0] random_channel();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h07;
      3:       return 8'hF8;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] random_coef();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'h4000;
      2:       return 16'h7FFF;
      3:       return 16'h8000;
      4:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // matrix row: near-identity, fully random, extreme or mixed coefficients
  function automatic logic [47:0] random_row(int diag);
    logic [47:0] row;
    int          c;
    row = '0;
    case ($urandom_range(0, 3))
      0: begin
        for (int j = 0; j < 3; j++) begin
          c = (j == diag ? 16384 : 0) + int'($urandom_range(0, 6000)) - 3000;
          row[j*16 +: 16] = 16'(c);
        end
      end
      1: row = {16'($urandom), $urandom};
      2: begin
        case ($urandom_range(0, 3))
          0:       row = 48'h0;
          1:       row = 48'hFFFF_FFFF_FFFF;
          2:       row = 48'h7FFF_7FFF_7FFF;
          default: row = 48'h8000_8000_8000;
        endcase
      end
      default: begin
        for (int j = 0; j < 3; j++) row[j*16 +: 16] = random_coef();
      end
    endcase
    return row;
  endfunction

  // reset state: correction off, pixels pass through
  task automatic test_passthrough();
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_pixel(8'h5A, 8'hA5, 8'h3C, 8'hC3, 1'b0);
  endtask

  // reset identity matrix, low source bits dropped
  task automatic test_identity_gamma();
    wait_idle();
    cfg_write(rpcc_pkg::REG_ENABLE, {16'($urandom), $urandom} | 48'h1);
    send_pixel(8'h12, 8'h07, 8'hF8, 8'h80, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h80, 8'h40, 8'h20, 8'h10, 1'b0);
    send_pixel(8'h00, 8'hF8, 8'h07, 8'hFF, 1'b1);
  endtask

  // matrices that push results below zero and above one
  task automatic test_out_of_gamut();
    logic [47:0] gamut_rows [4];
    gamut_rows = '{48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, 48'h0, 48'hFFFF_FFFF_FFFF};
    for (int i = 0; i < 4; i++) begin
      wait_idle();
      cfg_write(rpcc_pkg::REG_RED, gamut_rows[i]);
      cfg_write(rpcc_pkg::REG_GREEN, gamut_rows[i]);
      cfg_write(rpcc_pkg::REG_BLUE, gamut_rows[i]);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
      send_pixel(8'h7F, 8'h90, 8'h60, 8'h30, 1'b1);
    end
  endtask

  // disable again with junk in the upper register bits
  task automatic test_disable_again();
    wait_idle();
    cfg_write(rpcc_pkg::REG_ENABLE, 48'hFFFF_FFFF_FFFE);
    send_pixel(8'hC0, 8'h11, 8'hEE, 8'h77, 1'b0);
    send_pixel(8'h01, 8'hFE, 8'h02, 8'hFD, 1'b1);
  endtask

  // random register settings, random pixels; one phase runs without gaps
  task automatic test_random_phases();
    logic en;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      calm = (ph == 3);
      if (ph == 0) en = 1'b1;
      else if (ph == 5) en = 1'b0;
      else en = ($urandom_range(0, 5) != 0);
      cfg_write(rpcc_pkg::REG_ENABLE, {{16'($urandom), $urandom} & ~48'h1} | 48'(en));
      cfg_write(rpcc_pkg::REG_RED, random_row(0));
      cfg_write(rpcc_pkg::REG_GREEN, random_row(1));
      cfg_write(rpcc_pkg::REG_BLUE, random_row(2));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 9) < 7) begin
          send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     $urandom_range(0, 15) == 0);
        end else begin
          send_pixel(random_channel(), random_channel(), random_channel(), random_channel(),
                     $urandom_range(0, 15) == 0);
        end
      end
    end
    calm = 1'b0;
  endtask

  // main sequence
  initial begin
    pix_in.valid    = 1'b0;
    pix_in.alpha_in = '0;
    pix_in.red_in   = '0;
    pix_in.green_in = '0;
    pix_in.blue_in  = '0;
    pix_in.last_in  = 1'b0;
    pix_out.ready   = 1'b1;
    cfg.valid       = 1'b0;
    cfg.index       = rpcc_pkg::REG_ENABLE;
    cfg.data        = '0;
    calm            = 1'b0;
    errors          = 0;
    pixels_sent     = 0;
    pixels_checked  = 0;
    cfg_writes      = 0;
    cur_enable      = 1'b0;
    cur_rows[0]     = 48'd16384;
    cur_rows[1]     = 48'd16384 << 16;
    cur_rows[2]     = 48'd16384 << 32;
    build_srgb_edges();

    // reset
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_passthrough();
    test_identity_gamma();
    test_out_of_gamut();
    test_disable_again();
    test_random_phases();
    wait_idle();

    $display("covered %0d pixels (%0d checked) over %0d register writes,", pixels_sent,
             pixels_checked, cfg_writes);
    $display("including pass-through, identity, clamped and random matrices");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
